// ===== design/sufd_pkg.sv =====
// ----------------------------------------------------------------------------
// sufd_pkg
// shared constants and types for the serial sensor frame deframer
// ----------------------------------------------------------------------------
package sufd_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int FILL_W      = $clog2(FRAME_BYTES);
  localparam int LAST_IDX    = FRAME_BYTES - 1;

  localparam int BYTE_W  = 8;
  localparam int PPM_W   = 16;
  localparam int CFG_W   = 16;
  localparam int TICK_W  = 17;
  localparam int COUNT_W = 32;
  localparam int EV_W    = 3;
  localparam int REG_W   = 2;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [PPM_W-1:0]   ppm_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [TICK_W-1:0]  tick_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [EV_W-1:0]    event_t;
  typedef logic [REG_W-1:0]   reg_idx_t;
  typedef logic [FILL_W-1:0]  fill_t;

  // frame header
  localparam byte_t HDR0 = 8'h42;
  localparam byte_t HDR1 = 8'h4D;

  localparam tick_t TICK_SAT = {TICK_W{1'b1}};

  // request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // event codes
  localparam event_t EV_NONE  = 3'd0;
  localparam event_t EV_GOOD  = 3'd1;
  localparam event_t EV_CHK   = 3'd2;
  localparam event_t EV_RANGE = 3'd3;
  localparam event_t EV_IDLE  = 3'd4;

  // register indexes
  localparam reg_idx_t REG_PPM_MIN     = 2'd0;
  localparam reg_idx_t REG_PPM_MAX     = 2'd1;
  localparam reg_idx_t REG_IDLE_LIMIT  = 2'd2;
  localparam reg_idx_t REG_STALE_LIMIT = 2'd3;

  // reset values of the registers
  localparam cfg_t PPM_MIN_RST     = 16'd0;
  localparam cfg_t PPM_MAX_RST     = 16'd5000;
  localparam cfg_t IDLE_LIMIT_RST  = 16'd2500;
  localparam cfg_t STALE_LIMIT_RST = 16'd3000;

endpackage

// ===== design/sufd_feed_if.sv =====
// ----------------------------------------------------------------------------
// sufd_feed_if
// input channel: a received byte or a millisecond tick
// ----------------------------------------------------------------------------
interface sufd_feed_if;
  import sufd_pkg::*;

  logic  valid;
  logic  ready;
  logic  req_type;
  byte_t rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);

endinterface

// ===== design/sufd_report_if.sv =====
// ----------------------------------------------------------------------------
// sufd_report_if
// result channel: event, reported value and status
// ----------------------------------------------------------------------------
interface sufd_report_if;
  import sufd_pkg::*;

  logic   valid;
  logic   ready;
  event_t event_res;
  ppm_t   ppm_value;
  logic   stale;
  count_t good_frames;

  modport source (output valid, output event_res, output ppm_value, output stale,
                  output good_frames, input ready);
  modport sink   (input valid, input event_res, input ppm_value, input stale,
                  input good_frames, output ready);

endinterface

// ===== design/sensor_uart_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sensor_uart_frame_deframer
// parser for 16-byte serial sensor frames with 0x42 0x4d header and sum8 check
// ----------------------------------------------------------------------------
// Every item on feed is either one received byte or one millisecond tick, and
// every item gives exactly one item on report. The block takes one item per
// clock cycle while report is not stalled. An item passes through the input
// register and then the result register before its result is offered on
// report. The rate is set by the single state update per cycle: the byte
// window is a shift register and the frame checksum is kept as a running
// 8-bit sum, so no step walks the window. Registers are written through
// cfg_we / cfg_index / cfg_data and must only be changed while no item is in
// flight. There is no clearing pass after reset; window entries are only read
// below the fill count.
// ----------------------------------------------------------------------------
module sensor_uart_frame_deframer (
  input  logic                clk,
  input  logic                rst,
  sufd_feed_if.sink           feed,
  sufd_report_if.source       report,
  input  logic                cfg_we,
  input  sufd_pkg::reg_idx_t  cfg_index,
  input  sufd_pkg::cfg_t      cfg_data
);
  import sufd_pkg::*;

  // configuration registers
  cfg_t ppm_min;
  cfg_t ppm_max;
  cfg_t byte_idle_limit;
  cfg_t frame_stale_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppm_min           <= PPM_MIN_RST;
      ppm_max           <= PPM_MAX_RST;
      byte_idle_limit   <= IDLE_LIMIT_RST;
      frame_stale_limit <= STALE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PPM_MIN:     ppm_min           <= cfg_data;
        REG_PPM_MAX:     ppm_max           <= cfg_data;
        REG_IDLE_LIMIT:  byte_idle_limit   <= cfg_data;
        REG_STALE_LIMIT: frame_stale_limit <= cfg_data;
        default:         ppm_min           <= ppm_min;
      endcase
    end
  end

  // input register
  logic  st_valid;
  logic  st_type;
  byte_t st_byte;

  // result register
  logic   res_valid;
  event_t res_event;
  ppm_t   res_ppm;
  logic   res_stale;
  count_t res_count;

  // the pipeline moves when the result register is free or being drained
  logic advance;
  logic fire;

  assign advance    = !res_valid || report.ready;
  assign fire       = st_valid && advance;
  assign feed.ready = !st_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (feed.ready) begin
      st_valid <= feed.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.valid && feed.ready) begin
      st_type <= feed.req_type;
      st_byte <= feed.rx_byte;
    end
  end

  // parser state
  byte_t  window [FRAME_BYTES];
  fill_t  fill_count;
  byte_t  run_sum;      // sum mod 256 of the bytes now in the window
  ppm_t   held_ppm;
  count_t accepted_count;
  tick_t  idle_ticks;
  tick_t  since_frame_ticks;

  fill_t  fill_count_next;
  byte_t  run_sum_next;
  ppm_t   held_ppm_next;
  count_t accepted_count_next;
  tick_t  idle_ticks_next;
  tick_t  since_frame_ticks_next;
  event_t ev;
  logic   stale_next;
  logic   wr_en;
  logic   shift_en;
  logic   hdr_ok;
  ppm_t   frame_val;

  assign hdr_ok    = (window[0] == HDR0) && (window[1] == HDR1);
  assign frame_val = {window[6], window[7]};

  always_comb begin
    fill_count_next        = fill_count;
    run_sum_next           = run_sum;
    held_ppm_next          = held_ppm;
    accepted_count_next    = accepted_count;
    idle_ticks_next        = idle_ticks;
    since_frame_ticks_next = since_frame_ticks;
    ev                     = EV_NONE;
    wr_en                  = 1'b0;
    shift_en               = 1'b0;

    if (st_type == REQ_TICK) begin
      // both timers count up and stick at full scale
      if (idle_ticks != TICK_SAT) begin
        idle_ticks_next = idle_ticks + tick_t'(1);
      end
      if (since_frame_ticks != TICK_SAT) begin
        since_frame_ticks_next = since_frame_ticks + tick_t'(1);
      end
      // idle timeout drops a partial window
      if ((idle_ticks_next > tick_t'(byte_idle_limit)) && (fill_count != '0)) begin
        fill_count_next = '0;
        run_sum_next    = '0;
        ev              = EV_IDLE;
      end
      if ((accepted_count != '0) &&
          (since_frame_ticks_next > tick_t'(frame_stale_limit))) begin
        held_ppm_next = '0;
      end
    end else begin
      idle_ticks_next = '0;
      if (fill_count != fill_t'(LAST_IDX)) begin
        // window not yet full: append
        wr_en           = 1'b1;
        fill_count_next = fill_count + fill_t'(1);
        run_sum_next    = run_sum + st_byte;
      end else if (!hdr_ok) begin
        // full without header: slide by one byte
        shift_en     = 1'b1;
        run_sum_next = run_sum + st_byte - window[0];
      end else begin
        // full frame: run_sum covers bytes 0..14, the new byte is the checksum
        fill_count_next = '0;
        run_sum_next    = '0;
        if (run_sum != st_byte) begin
          ev = EV_CHK;
        end else if ((frame_val < ppm_min) || (frame_val > ppm_max)) begin
          ev = EV_RANGE;
        end else begin
          ev                     = EV_GOOD;
          held_ppm_next          = frame_val;
          since_frame_ticks_next = '0;
          accepted_count_next    = accepted_count + count_t'(1);
        end
      end
    end

    stale_next = (accepted_count_next != '0) &&
                 (since_frame_ticks_next > tick_t'(frame_stale_limit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count        <= '0;
      run_sum           <= '0;
      held_ppm          <= '0;
      accepted_count    <= '0;
      idle_ticks        <= '0;
      since_frame_ticks <= '0;
    end else if (fire) begin
      fill_count        <= fill_count_next;
      run_sum           <= run_sum_next;
      held_ppm          <= held_ppm_next;
      accepted_count    <= accepted_count_next;
      idle_ticks        <= idle_ticks_next;
      since_frame_ticks <= since_frame_ticks_next;
    end
  end

  // byte window: append at the fill point or slide toward entry zero
  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      window[fill_count] <= st_byte;
    end else if (fire && shift_en) begin
      for (int i = 0; i < LAST_IDX - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[LAST_IDX-1] <= st_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_event <= ev;
      res_ppm   <= held_ppm_next;
      res_stale <= stale_next;
      res_count <= accepted_count_next;
    end
  end

  assign report.valid       = res_valid;
  assign report.event_res   = res_event;
  assign report.ppm_value   = res_ppm;
  assign report.stale       = res_stale;
  assign report.good_frames = res_count;

endmodule
